// ----- rtl/fex_pkg.sv -----
// fex_pkg: shared constants, codes and types for the flag/escape/xor framer
// no dependencies; used by fex_step and the top level
package fex_pkg;

  localparam logic [7:0] FLAG_BYTE    = 8'h7E;
  localparam logic [7:0] ESC_BYTE     = 8'h7D;
  localparam logic [7:0] ESC_FOR_ESC  = 8'h01;
  localparam logic [7:0] ESC_FOR_FLAG = 8'h02;

  // most beats one item can produce: open flag, escaped byte, escaped sum, close flag
  localparam int MAX_BEATS = 6;
  localparam int CNT_W     = $clog2(MAX_BEATS + 1);
  localparam int IDX_W     = $clog2(MAX_BEATS);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CSUM  = 2'd1,
    ST_ESC   = 2'd2,
    ST_SHORT = 2'd3
  } fex_status_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    fex_status_t status;
  } fex_beat_t;

  typedef struct packed {
    logic       in_frame;
    logic       esc_pend;
    logic [7:0] csum;
    logic [7:0] held_byte;
    logic       held_v;
    logic       esc_err;
  } fex_state_t;

endpackage

// ----- rtl/fex_in_if.sv -----
// fex_in_if: input channel, valid/ready with one message or line byte per beat
// depends on nothing
interface fex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- rtl/fex_out_if.sv -----
// fex_out_if: result channel, valid/ready with one line byte or status per beat
// depends on nothing
interface fex_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic [1:0] status;

  modport source (output valid, output out_byte, output out_last, output status, input ready);
  modport sink   (input valid, input out_byte, input out_last, input status, output ready);
endinterface

// ----- rtl/fex_step.sv -----
// fex_step: per-item logic, turns one byte and the framer state into a beat list
// and the state after the item; depends on fex_pkg
module fex_step (
  input  logic                              encode,
  input  fex_pkg::fex_state_t               st,
  input  logic [7:0]                        in_byte,
  input  logic                              in_last,
  output fex_pkg::fex_beat_t                beats [fex_pkg::MAX_BEATS],
  output logic [fex_pkg::CNT_W-1:0]         cnt,
  output fex_pkg::fex_state_t               st_nxt
);

  logic [fex_pkg::CNT_W-1:0] n;
  logic [7:0]                x;
  logic [7:0]                d;
  logic                      have;
  fex_pkg::fex_status_t      fst;

  always_comb begin
    for (int i = 0; i < fex_pkg::MAX_BEATS; i++) begin
      beats[i] = '{data: 8'h00, last: 1'b0, status: fex_pkg::ST_OK};
    end
    n      = '0;
    st_nxt = st;
    x      = st.csum ^ in_byte;
    d      = in_byte;
    have   = 1'b0;
    fst    = fex_pkg::ST_OK;

    if (encode) begin
      // opening flag on the first byte of a message
      if (!st.in_frame) begin
        beats[n].data = fex_pkg::FLAG_BYTE;
        n = n + 1'b1;
      end
      if (in_byte == fex_pkg::FLAG_BYTE || in_byte == fex_pkg::ESC_BYTE) begin
        beats[n].data = fex_pkg::ESC_BYTE;
        beats[n + 1'b1].data = (in_byte == fex_pkg::FLAG_BYTE) ?
                               fex_pkg::ESC_FOR_FLAG : fex_pkg::ESC_FOR_ESC;
        n = n + 2'd2;
      end else begin
        beats[n].data = in_byte;
        n = n + 1'b1;
      end
      st_nxt.in_frame = 1'b1;
      st_nxt.csum     = x;
      if (in_last) begin
        // escaped checksum, then closing flag
        if (x == fex_pkg::FLAG_BYTE || x == fex_pkg::ESC_BYTE) begin
          beats[n].data = fex_pkg::ESC_BYTE;
          beats[n + 1'b1].data = (x == fex_pkg::FLAG_BYTE) ?
                                 fex_pkg::ESC_FOR_FLAG : fex_pkg::ESC_FOR_ESC;
          n = n + 2'd2;
        end else begin
          beats[n].data = x;
          n = n + 1'b1;
        end
        beats[n].data = fex_pkg::FLAG_BYTE;
        beats[n].last = 1'b1;
        n = n + 1'b1;
        st_nxt.in_frame = 1'b0;
        st_nxt.csum     = 8'h00;
      end
    end else if (in_byte == fex_pkg::FLAG_BYTE) begin
      st_nxt = '0;
      if (st.in_frame) begin
        if (st.esc_err || st.esc_pend) begin
          fst = fex_pkg::ST_ESC;
        end else if (!st.held_v) begin
          fst = fex_pkg::ST_SHORT;
        end else if (st.csum != 8'h00) begin
          fst = fex_pkg::ST_CSUM;
        end else begin
          fst = fex_pkg::ST_OK;
        end
        beats[0] = '{data: 8'h00, last: 1'b1, status: fst};
        n = n + 1'b1;
      end else begin
        st_nxt.in_frame = 1'b1;
      end
    end else if (st.in_frame) begin
      if (st.esc_pend) begin
        st_nxt.esc_pend = 1'b0;
        if (in_byte == fex_pkg::ESC_FOR_ESC) begin
          d    = fex_pkg::ESC_BYTE;
          have = 1'b1;
        end else if (in_byte == fex_pkg::ESC_FOR_FLAG) begin
          d    = fex_pkg::FLAG_BYTE;
          have = 1'b1;
        end else begin
          st_nxt.esc_err = 1'b1;
        end
      end else if (in_byte == fex_pkg::ESC_BYTE) begin
        st_nxt.esc_pend = 1'b1;
      end else begin
        have = 1'b1;
      end
      if (have) begin
        // held byte goes out one byte late, the last one is the checksum
        if (st.held_v) begin
          beats[0].data = st.held_byte;
          n = n + 1'b1;
        end
        st_nxt.held_byte = d;
        st_nxt.held_v    = 1'b1;
        st_nxt.csum      = st.csum ^ d;
      end
    end
    cnt = n;
  end

endmodule

// ----- rtl/flag_escape_xor_framer_top.sv -----
// flag_escape_xor_framer_top: byte framer/deframer with 7E flags, 7D escapes, xor sum
// a taken input byte enters the item register, its beats then load the result register
// an item holds the item register until its last result beat is loaded, stalling while
//   the result register is full and not drained; a flag+escape+sum+flag item has six beats
// reset (rst_n low, synchronous) clears mode to decode, framer state and both channels
// depends on fex_pkg, fex_in_if, fex_out_if, fex_step
module flag_escape_xor_framer_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  fex_in_if.sink           in_ch,
  fex_out_if.source        out_ch
);

  // configuration and framer state
  logic                         mode_r;
  fex_pkg::fex_state_t          st_r;

  // item register: the byte being expanded and the beat index into its list
  logic                         cur_v_r;
  logic [7:0]                   cur_byte_r;
  logic                         cur_last_r;
  logic [fex_pkg::IDX_W-1:0]    idx_r;

  // result register
  logic                         out_v_r;
  fex_pkg::fex_beat_t           out_beat_r;

  // per-item logic
  fex_pkg::fex_beat_t           beats [fex_pkg::MAX_BEATS];
  logic [fex_pkg::CNT_W-1:0]    cnt;
  fex_pkg::fex_state_t          st_nxt;

  logic                         can_load;
  logic                         load;
  logic                         last_beat;
  logic                         done;
  logic                         in_acc;

  fex_step u_step (
    .encode  (mode_r),
    .st      (st_r),
    .in_byte (cur_byte_r),
    .in_last (cur_last_r),
    .beats   (beats),
    .cnt     (cnt),
    .st_nxt  (st_nxt)
  );

  // result register is free when empty or being drained this cycle
  assign can_load  = !out_v_r || out_ch.ready;
  assign load      = cur_v_r && (cnt != '0) && can_load;
  assign last_beat = (fex_pkg::CNT_W'(idx_r) == cnt - 1'b1);
  // item finishes when its last beat moves out, or at once if it makes none
  assign done      = cur_v_r && ((cnt == '0) || (can_load && last_beat));
  // next item may enter in the same cycle the current one finishes
  assign in_ch.ready = !cur_v_r || done;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      st_r    <= '0;
      cur_v_r <= 1'b0;
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      // a mode write aborts any frame in progress
      if (cfg_we) begin
        mode_r <= cfg_wdata;
        st_r   <= '0;
      end else if (done) begin
        st_r <= st_nxt;
      end

      if (in_acc) begin
        cur_v_r <= 1'b1;
      end else if (done) begin
        cur_v_r <= 1'b0;
      end

      if (done) begin
        idx_r <= '0;
      end else if (load) begin
        idx_r <= idx_r + 1'b1;
      end

      if (load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_byte_r <= in_ch.in_byte;
      cur_last_r <= in_ch.in_last;
    end
    if (load) begin
      out_beat_r <= beats[idx_r];
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.out_byte = out_beat_r.data;
  assign out_ch.out_last = out_beat_r.last;
  assign out_ch.status   = out_beat_r.status;

  // beat index stays inside the item's beat list
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r && (cnt != '0) |-> (fex_pkg::CNT_W'(idx_r) < cnt))
    else $error("beat index past end of list");

  // a finished item leaves the index at zero for the next one
  a_idx_clear: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (idx_r == '0))
    else $error("beat index not cleared after item");

  // encode beats never carry a status code
  a_enc_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && mode_r |-> (out_beat_r.status == fex_pkg::ST_OK))
    else $error("status on an encode beat");

  // decode status beat carries a zero byte
  a_dec_stat_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !mode_r && out_beat_r.last |-> (out_beat_r.data == 8'h00))
    else $error("nonzero byte on decode status beat");

  // empty item register always takes a beat
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !cur_v_r |-> in_ch.ready)
    else $error("input stalled with empty item register");

endmodule
